@@ hdl/bank_mapper_with_scanline_irq_top_defines.svh @@
// Assertion macros for the checker file of the bank mapper.
// Depends on nothing; expects a clock named clk and a reset named rst in scope.
`ifndef BANK_MAPPER_WITH_SCANLINE_IRQ_TOP_DEFINES_SVH
`define BANK_MAPPER_WITH_SCANLINE_IRQ_TOP_DEFINES_SVH

// check a property outside reset
`define BMSI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every edge, reset included
`define BMSI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/bmsi_pkg.sv @@
// Package for the bank mapper with scanline interrupt counter.
// Holds the action codes, decoded register addresses and the result word layout.
`default_nettype none

package bmsi_pkg;

  localparam int unsigned AddrW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 24;

  localparam logic [AddrW-1:0] ADDR_MASK = 16'hF003;
  localparam logic [3:0] HI_CHR_LO = 4'hD;
  localparam logic [3:0] HI_CHR_HI = 4'hE;
  localparam logic [AddrW-1:0] REG_PRG16 = 16'h8000;
  localparam logic [AddrW-1:0] REG_PRG8 = 16'hC000;
  localparam logic [AddrW-1:0] REG_MIRROR = 16'hB003;
  localparam logic [AddrW-1:0] REG_SILENT = 16'h9003;
  localparam logic [AddrW-1:0] REG_RELOAD = 16'hF000;
  localparam logic [AddrW-1:0] REG_CONTROL = 16'hF001;
  localparam logic [AddrW-1:0] REG_ACK = 16'hF002;
  localparam logic [ByteW-1:0] COUNT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_PRG16  = 3'd1,
    ACT_PRG8   = 3'd2,
    ACT_CHR    = 3'd3,
    ACT_MIRROR = 3'd4
  } action_t;

  // packed from the top bit down: action ends up in the lowest bits
  typedef struct packed {
    logic             bad_write;
    logic             irq_request;
    logic [1:0]       mirror_mode;
    logic [ByteW-1:0] bank_number;
    logic [2:0]       chr_slot;
    action_t          action;
  } result_t;

  localparam int unsigned ResultW = $bits(result_t);

endpackage

`default_nettype wire

@@ hdl/bmsi_core.sv @@
// Write decoder and scanline interrupt counter of the bank mapper.
// Depends on bmsi_pkg; state advances only when the top level moves a word on.
`default_nettype none

module bmsi_core
  import bmsi_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic             kind,
  input  wire logic [AddrW-1:0] address,
  input  wire logic [ByteW-1:0] data_byte,
  output result_t               res
);

  logic [ByteW-1:0] tick_count, tick_count_next;
  logic [ByteW-1:0] reload_value, reload_value_next;
  logic             irq_on, irq_on_next;
  logic             repeat_mode, repeat_mode_next;

  logic [AddrW-1:0] reg_addr;
  logic [3:0]       hi;

  assign reg_addr = address & ADDR_MASK;
  assign hi       = reg_addr[15:12];

  always_comb begin
    res               = '0;
    res.action        = ACT_NONE;
    tick_count_next   = tick_count;
    reload_value_next = reload_value;
    irq_on_next       = irq_on;
    repeat_mode_next  = repeat_mode;
    if (kind) begin
      if (irq_on) begin
        if (tick_count == COUNT_MAX) begin
          tick_count_next = reload_value;
          res.irq_request = 1'b1;
          irq_on_next     = repeat_mode;
        end else begin
          tick_count_next = tick_count + 8'd1;
        end
      end
    end else if (hi == HI_CHR_LO || hi == HI_CHR_HI) begin
      res.action      = ACT_CHR;
      res.chr_slot    = {hi == HI_CHR_HI, reg_addr[1:0]};
      res.bank_number = data_byte;
    end else begin
      unique case (reg_addr)
        REG_PRG16: begin
          res.action      = ACT_PRG16;
          res.bank_number = data_byte;
        end
        REG_PRG8: begin
          res.action      = ACT_PRG8;
          res.bank_number = data_byte;
        end
        REG_MIRROR: begin
          res.action      = ACT_MIRROR;
          res.mirror_mode = data_byte[3:2];
        end
        REG_SILENT: begin
        end
        REG_RELOAD: begin
          reload_value_next = data_byte;
        end
        REG_CONTROL: begin
          irq_on_next      = data_byte[1];
          repeat_mode_next = data_byte[0];
          if (data_byte[1]) begin
            tick_count_next = reload_value;
          end
        end
        REG_ACK: begin
          irq_on_next = repeat_mode;
        end
        default: begin
          res.bad_write = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      reload_value <= '0;
      irq_on       <= 1'b0;
      repeat_mode  <= 1'b0;
    end else if (fire) begin
      tick_count   <= tick_count_next;
      reload_value <= reload_value_next;
      irq_on       <= irq_on_next;
      repeat_mode  <= repeat_mode_next;
    end
  end

endmodule

`default_nettype wire

@@ hdl/bank_mapper_with_scanline_irq_top.sv @@
// Top level of the bank mapper with scanline interrupt counter.
// Depends on bmsi_pkg and bmsi_core.
//
//   channel   direction  tdata                          tuser
//   s_axis    in         address, data_byte             kind
//   m_axis    out        action, chr_slot, bank_number, -
//                        mirror_mode, irq_request,
//                        bad_write
//
// One word in per cycle while m_axis is not stalled, one result word out per word in;
// each word passes the input register, then the result register. The decode and
// counter update sit between the two registers. Reset is synchronous and clears the
// counter state and both valid flags. A stall on m_axis backs up through one input
// stage before s_axis_tready drops.
`default_nettype none

module bank_mapper_with_scanline_irq_top
  import bmsi_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // address[15:0], data_byte[23:16]
  input  wire logic                s_axis_tuser,  // kind
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata   // action[2:0], chr_slot[5:3],
                                                  // bank_number[13:6], mirror_mode[15:14],
                                                  // irq_request[16], bad_write[17]
);

  logic             in_valid;
  logic             in_kind;
  logic [AddrW-1:0] in_address;
  logic [ByteW-1:0] in_byte;
  logic             fire;
  result_t          res;
  result_t          out_res;

  assign fire          = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind    <= s_axis_tuser;
      in_address <= s_axis_tdata[AddrW-1:0];
      in_byte    <= s_axis_tdata[AddrW+ByteW-1:AddrW];
    end
  end

  bmsi_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .kind      (in_kind),
    .address   (in_address),
    .data_byte (in_byte),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {{(OutDataW-ResultW){1'b0}}, out_res};

endmodule

`default_nettype wire

@@ hdl/bmsi_checker.sv @@
// Port-level checker for the bank mapper, bound to the top level.
// Depends on bank_mapper_with_scanline_irq_top_defines.svh.
`default_nettype none
`include "bank_mapper_with_scanline_irq_top_defines.svh"

module bmsi_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  `BMSI_ASSERT_ALWAYS(a_reset_clears_out, rst |=> !m_axis_tvalid, "result valid after reset")
  `BMSI_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")
  `BMSI_ASSERT(a_irq_clean, m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[15:0] == 16'h0 && !m_axis_tdata[17], "interrupt word carries a bank action")
  `BMSI_ASSERT(a_bad_clean, m_axis_tvalid && m_axis_tdata[17] |-> m_axis_tdata[16:0] == 17'h0, "flagged write carries other fields")
  `BMSI_ASSERT(a_no_result_from_idle, !$past(m_axis_tvalid) && !$past(s_axis_tvalid && s_axis_tready, 2) |-> !m_axis_tvalid, "result appeared with nothing in flight")

endmodule

bind bank_mapper_with_scanline_irq_top bmsi_checker u_bmsi_checker (.*);

`default_nettype wire

@@ tb/sv/bank_mapper_with_scanline_irq_top_tb.sv @@
// Self-checking testbench for bank_mapper_with_scanline_irq_top: bus writes and scanline
// ticks go in on s_axis, and each result word is compared with an in-bench mapper model.
// Depends on bmsi_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module bank_mapper_with_scanline_irq_top_tb
  import bmsi_pkg::*;
();

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_TICK = 1'b1;
  localparam logic [ByteW-1:0] CTRL_ENABLE = 8'h02;
  localparam logic [ByteW-1:0] CTRL_REPEAT = 8'h01;
  localparam logic [ByteW-1:0] CTRL_OFF = 8'h00;
  localparam int RANDOM_ITEMS = 1250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  logic [ByteW-1:0] line_count;
  logic [ByteW-1:0] reload_latch;
  logic irq_enabled;
  logic irq_repeat;
  logic no_gaps = 1'b0;
  int mismatches = 0;
  result_t pending_results[$];

  bank_mapper_with_scanline_irq_top DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t map_word(input logic kind, input logic [AddrW-1:0] addr,
                                       input logic [ByteW-1:0] data);
    result_t res;
    logic [AddrW-1:0] reg_addr;
    res = '0;
    res.action = ACT_NONE;
    reg_addr = addr & ADDR_MASK;
    if (kind == KIND_TICK) begin
      if (irq_enabled) begin
        if (line_count == COUNT_MAX) begin
          line_count = reload_latch;
          res.irq_request = 1'b1;
          irq_enabled = irq_repeat;
        end else begin
          line_count = line_count + 8'd1;
        end
      end
    end else if (reg_addr[15:12] == HI_CHR_LO || reg_addr[15:12] == HI_CHR_HI) begin
      res.action = ACT_CHR;
      res.chr_slot = {reg_addr[15:12] == HI_CHR_HI, reg_addr[1:0]};
      res.bank_number = data;
    end else begin
      case (reg_addr)
        REG_PRG16: begin
          res.action = ACT_PRG16;
          res.bank_number = data;
        end
        REG_PRG8: begin
          res.action = ACT_PRG8;
          res.bank_number = data;
        end
        REG_MIRROR: begin
          res.action = ACT_MIRROR;
          res.mirror_mode = data[3:2];
        end
        REG_SILENT: ;
        REG_RELOAD: reload_latch = data;
        REG_CONTROL: begin
          irq_enabled = data[1];
          irq_repeat = data[0];
          if (irq_enabled) line_count = reload_latch;
        end
        REG_ACK: irq_enabled = irq_repeat;
        default: res.bad_write = 1'b1;
      endcase
    end
    return res;
  endfunction

  function automatic logic [AddrW-1:0] mirror_bits();
    return AddrW'($urandom) & 16'h0FFC;
  endfunction

  task automatic send_word(input logic kind, input logic [AddrW-1:0] addr,
                           input logic [ByteW-1:0] data);
    while (!no_gaps && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {data, addr};
    s_axis_tuser <= kind;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(map_word(kind, addr, data));
  endtask

  task automatic test_bank_selects();
    send_word(KIND_WRITE, REG_PRG16, 8'h00);
    send_word(KIND_WRITE, REG_PRG8 | 16'h0FFC, 8'hFF);
    for (int slot = 0; slot < 8; slot++)
      send_word(KIND_WRITE, {(slot < 4) ? HI_CHR_LO : HI_CHR_HI, 10'($urandom), 2'(slot)},
                8'($urandom));
    send_word(KIND_WRITE, REG_MIRROR, 8'h0C);
    send_word(KIND_WRITE, REG_MIRROR | 16'h0FFC, 8'hF3);
    send_word(KIND_WRITE, REG_SILENT | 16'h0FFC, 8'hFF);
    send_word(KIND_WRITE, 16'h0000, 8'h00);
    send_word(KIND_WRITE, 16'hFFFF, 8'hFF);
  endtask

  task automatic test_irq_counter();
    send_word(KIND_TICK, 16'hFFFF, 8'hFF);
    send_word(KIND_WRITE, REG_RELOAD, 8'hFE);
    send_word(KIND_WRITE, REG_CONTROL, CTRL_ENABLE);
    send_word(KIND_TICK, 16'h0000, 8'h00);
    send_word(KIND_TICK, 16'h0000, 8'h00);
    send_word(KIND_TICK, 16'h0000, 8'h00);
    send_word(KIND_WRITE, REG_CONTROL, CTRL_REPEAT);
    send_word(KIND_WRITE, REG_ACK, 8'h00);
    send_word(KIND_TICK, REG_ACK, 8'hFF);
    send_word(KIND_TICK, REG_ACK, 8'hFF);
    send_word(KIND_TICK, REG_ACK, 8'hFF);
    send_word(KIND_WRITE, REG_CONTROL, 8'hFF);
    send_word(KIND_WRITE, REG_CONTROL, CTRL_OFF);
  endtask

  task automatic test_random_traffic();
    int sent;
    int pick;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_gaps = (sent >= 400 && sent < 650);
      data = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(255, 224));
      send_word(KIND_WRITE, REG_RELOAD | mirror_bits(), data);
      data = 8'($urandom) | (($urandom_range(4) != 0) ? CTRL_ENABLE : CTRL_OFF);
      send_word(KIND_WRITE, REG_CONTROL | mirror_bits(), data);
      sent += 2;
      repeat ($urandom_range(60, 5)) begin
        pick = $urandom_range(99);
        addr = AddrW'($urandom);
        data = 8'($urandom);
        if (pick < 60) begin
          send_word(KIND_TICK, addr, data);
        end else if (pick < 68) begin
          addr = {$urandom_range(1) ? HI_CHR_HI : HI_CHR_LO, addr[11:0]};
          send_word(KIND_WRITE, addr, data);
        end else if (pick < 76) begin
          case ($urandom_range(2))
            0: addr = REG_PRG16 | mirror_bits();
            1: addr = REG_PRG8 | mirror_bits();
            default: addr = REG_MIRROR | mirror_bits();
          endcase
          send_word(KIND_WRITE, addr, data);
        end else if (pick < 81) begin
          send_word(KIND_WRITE, REG_ACK | mirror_bits(), data);
        end else if (pick < 84) begin
          send_word(KIND_WRITE, REG_SILENT | mirror_bits(), data);
        end else if (pick < 87) begin
          send_word(KIND_WRITE, ($urandom_range(1) ? REG_RELOAD : REG_CONTROL) | mirror_bits(),
                    data);
        end else begin
          send_word(KIND_WRITE, addr, data);
        end
        sent++;
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic report_field(input string field, input int unsigned want,
                              input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= no_gaps || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[ResultW-1:0]);
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, got %h", $time, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        report_field("action", want.action, got.action);
        report_field("chr_slot", want.chr_slot, got.chr_slot);
        report_field("bank_number", want.bank_number, got.bank_number);
        report_field("mirror_mode", want.mirror_mode, got.mirror_mode);
        report_field("irq_request", want.irq_request, got.irq_request);
        report_field("bad_write", want.bad_write, got.bad_write);
      end
    end
  end

  initial begin
    line_count = '0;
    reload_latch = '0;
    irq_enabled = 1'b0;
    irq_repeat = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_bank_selects();
    test_irq_counter();
    test_random_traffic();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
